// File: design/cdd_pkg.sv
// Package with the types, codes and month table of the calendar date decrement block.
package cdd_pkg;

    // Function codes of a request.
    localparam logic [2:0] FUNC_DAYS       = 3'd0;
    localparam logic [2:0] FUNC_WEEKS      = 3'd1;
    localparam logic [2:0] FUNC_MONTHS     = 3'd2;
    localparam logic [2:0] FUNC_YEARS      = 3'd3;
    localparam logic [2:0] FUNC_DECADES    = 3'd4;
    localparam logic [2:0] FUNC_CENTURY    = 3'd5;
    localparam logic [2:0] FUNC_MILLENNIUM = 3'd6;

    // Calendar limits.
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [4:0]  DAY_LEAP    = 5'd29;
    localparam logic [4:0]  DAY_NONLEAP = 5'd28;
    localparam logic [4:0]  DAY_DEC_END = 5'd31;

    // Width of the shared step counter; it also holds the year amount to subtract.
    localparam int CNT_W = 20;

    // Fixed year amounts of the century and millennium codes.
    localparam logic [CNT_W-1:0] SUB_CENTURY    = 20'd100;
    localparam logic [CNT_W-1:0] SUB_MILLENNIUM = 20'd1000;

    // Month lengths of a common year, indexed by month; entry 0 is unused.
    localparam logic [4:0] MONTH_LEN [0:15] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_DAY,
        ST_MON,
        ST_MON_CLAMP,
        ST_YEAR,
        ST_YEAR_FIX,
        ST_FINISH
    } cdd_state_t;

    // Request payload.
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] count;
        logic [4:0]  in_day;
        logic [3:0]  in_month;
        logic [13:0] in_year;
    } cdd_req_t;

    // Response payload.
    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        underflow;
    } cdd_rsp_t;

    // Length of a month, given whether the year is a leap year.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = MONTH_LEN[month];
        if (month == MONTH_FEB && leap)
        begin
            len = DAY_LEAP;
        end
        return len;
    endfunction

endpackage

// File: design/cdd_stream_if.sv
// Valid/ready stream interface that carries one payload per handshake.
interface cdd_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: design/cdd_leap.sv
// Gregorian leap year test for years 0 to 9999, shared by all date steps.
module cdd_leap (
    input  logic [13:0] year,
    output logic        leap
);
    import cdd_pkg::*;

    logic [26:0] prod;
    logic [6:0]  quot;
    logic [13:0] hundreds;
    logic        div100;

    // Divide by 100 through the reciprocal 5243 / 2^19, exact for years up to 9999.
    assign prod     = {13'd0, year} * 27'd5243;
    assign quot     = prod[25:19];
    assign hundreds = {1'b0, quot, 6'd0} + {2'b0, quot, 5'd0} + {5'd0, quot, 2'd0};
    assign div100   = (hundreds == year);

    // Divisible by 4 and not by 100, or divisible by 400.
    assign leap = (year[1:0] == 2'd0 && !div100) || (div100 && quot[1:0] == 2'd0);

endmodule

// File: design/calendar_date_decrement.sv
// Top level of the calendar date decrement block: sequencer, date registers and response register.
//
// The block takes a Gregorian date with a function code and a count on the req stream and
// returns the earlier date on the rsp stream. One request is worked on at a time; req.ready is
// high only while the sequencer is idle. After acceptance the ST_NORM state normalizes the start
// date, then day and week codes walk back up to count or 7 * count days, one day per cycle, in
// ST_DAY; the month code alternates a month step in ST_MON with a day clamp in ST_MON_CLAMP, and
// the year-based codes pass through ST_YEAR and ST_YEAR_FIX; an unused code skips to ST_FINISH.
// ST_FINISH loads the response register once it is empty or being taken. The walk is set by the
// single day/month step unit and the one leap year test it shares. A finished response waits in
// its register while the next request is already accepted and worked on.
module calendar_date_decrement (
    input  logic         clk,
    input  logic         rst_n,
    cdd_stream_if.sink   req,
    cdd_stream_if.source rsp
);
    import cdd_pkg::*;

    cdd_state_t       state_reg, state_next;
    logic [2:0]       func_reg, func_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [4:0]       d_reg, d_next;
    logic [3:0]       m_reg, m_next;
    logic [13:0]      y_reg, y_next;
    logic             uf_reg, uf_next;
    cdd_rsp_t         out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             leap;
    logic [4:0]       cur_len;
    logic [4:0]       prev_len;
    logic             req_fire;
    logic             out_load;
    logic [CNT_W-1:0] cnt_ext;
    logic [CNT_W-1:0] year_ext;

    // Shared leap year test on the working year.
    cdd_leap u_leap (
        .year (y_reg),
        .leap (leap)
    );

    assign cur_len  = days_in(m_reg, leap);
    assign prev_len = days_in(m_reg - 4'd1, leap);
    assign cnt_ext  = {{(CNT_W-16){1'b0}}, req.payload.count};
    assign year_ext = {{(CNT_W-14){1'b0}}, y_reg};
    assign req_fire = req.valid && req.ready;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                case (func_reg) inside
                    FUNC_DAYS, FUNC_WEEKS:                          state_next = ST_DAY;
                    FUNC_MONTHS:                                    state_next = ST_MON;
                    FUNC_YEARS, FUNC_DECADES, FUNC_CENTURY,
                    FUNC_MILLENNIUM:                                state_next = ST_YEAR;
                    default:                                        state_next = ST_FINISH;
                endcase
            end
            ST_DAY:
            begin
                if (cnt_reg == '0 || (d_reg == 5'd1 && m_reg == 4'd1 && y_reg == '0))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MON:
            begin
                if (cnt_reg == '0 || (m_reg == 4'd1 && y_reg == '0))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MON_CLAMP;
                end
            end
            ST_MON_CLAMP: state_next = ST_MON;
            ST_YEAR:      state_next = ST_YEAR_FIX;
            ST_YEAR_FIX:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        req.ready   = (state_reg == ST_IDLE);
        rsp.valid   = out_valid_reg;
        rsp.payload = out_reg;
    end

    // Datapath of the date registers and the step counter.
    always_comb
    begin
        func_next      = func_reg;
        cnt_next       = cnt_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        y_next         = y_reg;
        uf_next        = uf_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    func_next = req.payload.func;
                    uf_next   = 1'b0;
                    // Clamp month, year and a zero day; the month length clamp follows.
                    if (req.payload.in_month == 4'd0)
                    begin
                        m_next = 4'd1;
                    end
                    else if (req.payload.in_month > MONTH_DEC)
                    begin
                        m_next = MONTH_DEC;
                    end
                    else
                    begin
                        m_next = req.payload.in_month;
                    end
                    y_next = (req.payload.in_year > YEAR_MAX) ? YEAR_MAX : req.payload.in_year;
                    d_next = (req.payload.in_day == 5'd0) ? 5'd1 : req.payload.in_day;
                    // Number of steps, or the amount of years to subtract.
                    case (req.payload.func)
                        FUNC_WEEKS:      cnt_next = (cnt_ext << 3) - cnt_ext;
                        FUNC_DECADES:    cnt_next = (cnt_ext << 3) + (cnt_ext << 1);
                        FUNC_CENTURY:    cnt_next = SUB_CENTURY;
                        FUNC_MILLENNIUM: cnt_next = SUB_MILLENNIUM;
                        default:         cnt_next = cnt_ext;
                    endcase
                end
            end
            ST_NORM:
            begin
                if (d_reg > cur_len)
                begin
                    d_next = cur_len;
                end
            end
            ST_DAY:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (d_reg > 5'd1)
                    begin
                        d_next = d_reg - 5'd1;
                    end
                    else if (m_reg > 4'd1)
                    begin
                        m_next = m_reg - 4'd1;
                        d_next = prev_len;
                    end
                    else if (y_reg != '0)
                    begin
                        y_next = y_reg - 14'd1;
                        m_next = MONTH_DEC;
                        d_next = DAY_DEC_END;
                    end
                    else
                    begin
                        uf_next = 1'b1;
                    end
                end
            end
            ST_MON:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (m_reg > 4'd1)
                    begin
                        m_next = m_reg - 4'd1;
                    end
                    else if (y_reg != '0)
                    begin
                        y_next = y_reg - 14'd1;
                        m_next = MONTH_DEC;
                    end
                    else
                    begin
                        d_next  = 5'd1;
                        uf_next = 1'b1;
                    end
                end
            end
            ST_MON_CLAMP:
            begin
                if (d_reg > cur_len)
                begin
                    d_next = cur_len;
                end
            end
            ST_YEAR:
            begin
                if (cnt_reg > year_ext)
                begin
                    y_next  = '0;
                    uf_next = 1'b1;
                end
                else
                begin
                    y_next = y_reg - cnt_reg[13:0];
                end
            end
            ST_YEAR_FIX:
            begin
                // A Feb 29 that lands in a common year becomes Feb 28.
                if (m_reg == MONTH_FEB && d_reg == DAY_LEAP && !leap)
                begin
                    d_next = DAY_NONLEAP;
                end
            end
            default:
            begin
            end
        endcase

        // Response register: cleared when taken, loaded when the sequencer finishes.
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next    = 1'b1;
            out_next.out_day   = d_reg;
            out_next.out_month = m_reg;
            out_next.out_year  = y_reg;
            out_next.underflow = uf_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        cnt_reg  <= cnt_next;
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        uf_reg   <= uf_next;
        out_reg  <= out_next;
    end

endmodule

// File: tb/date_check_pkg.sv
// Scoreboard class for the calendar date decrement testbench: date predictor and response checks.
`timescale 1ns / 1ps

package date_check_pkg;

    import cdd_pkg::*;

    // One accepted request together with the date it should produce.
    typedef struct {
        cdd_req_t req;
        cdd_rsp_t rsp;
    } pending_date_t;

    class date_scoreboard;

        // Mismatch lines stop after this many have been printed; counting goes on.
        localparam int PRINT_LIMIT = 40;

        pending_date_t awaited_dates[$];
        cdd_req_t      current_req;
        int unsigned   accepted_count;
        int unsigned   checked_count;
        int unsigned   mismatch_count;
        int unsigned   underflow_count;

        function new();
            accepted_count  = 0;
            checked_count   = 0;
            mismatch_count  = 0;
            underflow_count = 0;
        endfunction

        // Gregorian leap rule; year 0 counts as a leap year.
        function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // Length of month m (1..12) in year y.
        function int unsigned month_days(int unsigned m, int unsigned y);
            case (m)
                2: return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        // Works out the earlier date that a request should produce.
        function cdd_rsp_t earlier_date(cdd_req_t r);
            int unsigned d;
            int unsigned m;
            int unsigned y;
            int unsigned steps;
            int unsigned sub;
            bit          uf;
            cdd_rsp_t    res;
            d  = r.in_day;
            m  = r.in_month;
            y  = r.in_year;
            uf = 1'b0;

            // Out-of-range start fields are pulled into the calendar first.
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            if (y > 9999) y = 9999;
            if (d < 1) d = 1;
            if (d > month_days(m, y)) d = month_days(m, y);

            case (r.func)
                FUNC_DAYS, FUNC_WEEKS:
                begin
                    steps = (r.func == FUNC_WEEKS) ? int'(r.count) * 7 : int'(r.count);
                    for (int unsigned i = 0; i < steps; i++)
                    begin
                        if (d > 1)
                        begin
                            d--;
                        end
                        else if (m > 1)
                        begin
                            m--;
                            d = month_days(m, y);
                        end
                        else if (y > 0)
                        begin
                            y--;
                            m = 12;
                            d = 31;
                        end
                        else
                        begin
                            d  = 1;
                            m  = 1;
                            uf = 1'b1;
                            break;
                        end
                    end
                end
                FUNC_MONTHS:
                begin
                    for (int unsigned i = 0; i < r.count; i++)
                    begin
                        if (m > 1)
                        begin
                            m--;
                        end
                        else if (y > 0)
                        begin
                            y--;
                            m = 12;
                        end
                        else
                        begin
                            d  = 1;
                            m  = 1;
                            uf = 1'b1;
                            break;
                        end
                        if (d > month_days(m, y)) d = month_days(m, y);
                    end
                end
                FUNC_YEARS, FUNC_DECADES, FUNC_CENTURY, FUNC_MILLENNIUM:
                begin
                    case (r.func)
                        FUNC_YEARS:   sub = r.count;
                        FUNC_DECADES: sub = int'(r.count) * 10;
                        FUNC_CENTURY: sub = 100;
                        default:      sub = 1000;
                    endcase
                    if (sub > y)
                    begin
                        y  = 0;
                        uf = 1'b1;
                    end
                    else
                    begin
                        y -= sub;
                    end
                    // A leap day that lands in a common year becomes Feb 28.
                    if (m == 2 && d == 29 && !leap_year(y)) d = 28;
                end
                default:
                begin
                end
            endcase

            res.out_day   = d[4:0];
            res.out_month = m[3:0];
            res.out_year  = y[13:0];
            res.underflow = uf;
            return res;
        endfunction

        // Notes a request accepted by the block and queues its expected date.
        function void note_request(cdd_req_t r);
            pending_date_t entry;
            entry.req = r;
            entry.rsp = earlier_date(r);
            awaited_dates.push_back(entry);
            accepted_count++;
        endfunction

        function int pending();
            return awaited_dates.size();
        endfunction

        // Counts a mismatch and prints one line for it, up to PRINT_LIMIT lines.
        task report(string what, int unsigned got, int unsigned want);
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT)
            begin
                $display("%0t %s mismatch: got %0d, want %0d (func %0d cnt %0d date %0d-%0d-%0d)",
                         $time, what, got, want, current_req.func, current_req.count,
                         current_req.in_year, current_req.in_month, current_req.in_day);
            end
        endtask

        // Compares a response with the oldest expected date, field by field.
        task check_response(cdd_rsp_t got);
            pending_date_t entry;
            if (awaited_dates.size() == 0)
            begin
                current_req = '0;
                report("response with no request pending", got.out_year, 0);
            end
            else
            begin
                entry       = awaited_dates.pop_front();
                current_req = entry.req;
                checked_count++;
                if (got.underflow) underflow_count++;
                if (got.out_day !== entry.rsp.out_day)
                    report("out_day", got.out_day, entry.rsp.out_day);
                if (got.out_month !== entry.rsp.out_month)
                    report("out_month", got.out_month, entry.rsp.out_month);
                if (got.out_year !== entry.rsp.out_year)
                    report("out_year", got.out_year, entry.rsp.out_year);
                if (got.underflow !== entry.rsp.underflow)
                    report("underflow", got.underflow, entry.rsp.underflow);
            end
        endtask

    endclass

endpackage

// File: tb/tb_calendar_date_decrement.sv
// Top level of the calendar date decrement testbench: clock, reset, request and response drivers.
`timescale 1ns / 1ps

module tb_calendar_date_decrement;

    import cdd_pkg::*;
    import date_check_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int RANDOM_ITEMS  = 100;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_STRETCH  = 300;
    localparam int IDLE_PCT      = 34;
    localparam int QUIET_FIRST   = 50;
    localparam int QUIET_LAST    = 80;

    // Function code that the block does not define; it returns the normalized start date.
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    bit   gaps_on = 1'b1;
    bit   hold_trigger = 1'b0;
    int   directed_count;

    date_scoreboard dates;

    cdd_stream_if #(.payload_t(cdd_req_t)) req_if ();
    cdd_stream_if #(.payload_t(cdd_rsp_t)) rsp_if ();

    calendar_date_decrement uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Builds a request from plain integers.
    function automatic cdd_req_t date_req(logic [2:0] f, int c, int d, int m, int y);
        cdd_req_t r;
        r.func     = f;
        r.count    = c[15:0];
        r.in_day   = d[4:0];
        r.in_month = m[3:0];
        r.in_year  = y[13:0];
        return r;
    endfunction

    // Random request; walk counts are mostly small so the run stays short.
    function automatic cdd_req_t random_date_req();
        cdd_req_t r;
        int       sel;
        sel    = $urandom_range(99);
        r.func = (sel < 5) ? FUNC_UNUSED : 3'($urandom_range(6));

        sel = $urandom_range(99);
        if (sel < 10)
            r.in_year = 14'($urandom_range(3));
        else if (sel < 20)
            r.in_year = 14'($urandom_range(16383));
        else
            r.in_year = 14'($urandom_range(9999));
        r.in_month = ($urandom_range(99) < 90) ? 4'($urandom_range(12, 1))
                                                : 4'($urandom_range(15));
        r.in_day   = 5'($urandom_range(31));

        // Leap days in years divisible by 4 exercise the Feb 29 repair.
        if ($urandom_range(9) == 0)
        begin
            r.in_month = MONTH_FEB;
            r.in_day   = DAY_LEAP;
            r.in_year  = 14'(4 * $urandom_range(2499));
        end

        case (r.func)
            FUNC_DAYS:
                r.count = ($urandom_range(19) == 0) ? 16'($urandom_range(3000))
                                                    : 16'($urandom_range(60));
            FUNC_WEEKS:
                r.count = ($urandom_range(19) == 0) ? 16'($urandom_range(400))
                                                    : 16'($urandom_range(10));
            FUNC_MONTHS:
                r.count = ($urandom_range(19) == 0) ? 16'($urandom_range(1000))
                                                    : 16'($urandom_range(40));
            default:
                r.count = ($urandom_range(1) == 0) ? 16'($urandom_range(65535))
                                                   : 16'($urandom_range(30));
        endcase
        return r;
    endfunction

    // Offers one request, with random gaps ahead of it, and waits for acceptance.
    task automatic send_date_request(input cdd_req_t r);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        dates.note_request(r);
    endtask

    // Response side: checks each accepted response and drives ready.
    initial
    begin : response_side
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                dates.check_response(rsp_if.payload);
            if (hold_trigger)
            begin
                hold_trigger = 1'b0;
                hold_left    = HOLD_STRETCH;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (gaps_on)
            begin
                rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Request side and end of run.
    initial
    begin : request_side
        dates = new();
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: zero count, boundary crossings and leap rules.
        send_date_request(date_req(FUNC_DAYS, 0, 15, 6, 2024));
        send_date_request(date_req(FUNC_DAYS, 1, 1, 1, 2000));
        send_date_request(date_req(FUNC_DAYS, 1, 1, 3, 1900));
        send_date_request(date_req(FUNC_DAYS, 1, 1, 3, 2000));
        // Largest counts on the walking codes, from the latest date.
        send_date_request(date_req(FUNC_DAYS, 65535, 31, 12, 9999));
        send_date_request(date_req(FUNC_WEEKS, 65535, 31, 12, 9999));
        send_date_request(date_req(FUNC_MONTHS, 65535, 31, 12, 9999));
        // Walks that run past year 0.
        send_date_request(date_req(FUNC_DAYS, 10, 5, 1, 0));
        send_date_request(date_req(FUNC_WEEKS, 1, 3, 1, 0));
        send_date_request(date_req(FUNC_MONTHS, 13, 15, 6, 0));
        // Month step clamps the day to a shorter month.
        send_date_request(date_req(FUNC_MONTHS, 1, 31, 3, 2023));
        // Year-based codes, the leap day repair and saturation at year 0.
        send_date_request(date_req(FUNC_YEARS, 1, 29, 2, 2000));
        send_date_request(date_req(FUNC_YEARS, 65535, 10, 10, 9999));
        send_date_request(date_req(FUNC_YEARS, 0, 30, 2, 2004));
        send_date_request(date_req(FUNC_DECADES, 4, 29, 2, 40));
        send_date_request(date_req(FUNC_DECADES, 65535, 1, 7, 5000));
        send_date_request(date_req(FUNC_CENTURY, 0, 29, 2, 2000));
        send_date_request(date_req(FUNC_CENTURY, 123, 29, 2, 96));
        send_date_request(date_req(FUNC_MILLENNIUM, 65535, 1, 1, 9999));
        send_date_request(date_req(FUNC_MILLENNIUM, 0, 0, 0, 0));
        // Out-of-range start fields and the unused code.
        send_date_request(date_req(FUNC_UNUSED, 65535, 0, 0, 16383));
        send_date_request(date_req(FUNC_DAYS, 0, 31, 15, 12345));
        send_date_request(date_req(FUNC_DAYS, 0, 31, 2, 2023));
        directed_count = dates.accepted_count;

        // Random requests; the response side first holds off long enough to back up the block.
        hold_trigger = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == QUIET_FIRST) gaps_on = 1'b0;
            if (i == QUIET_LAST) gaps_on = 1'b1;
            send_date_request(random_date_req());
        end
        req_if.valid <= 1'b0;

        // Let every response arrive, then watch for stray ones.
        while (dates.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d directed, %0d random) over %0d cycles.",
                 dates.accepted_count, directed_count,
                 dates.accepted_count - directed_count, cycle_count);
        $display("Checked %0d responses, %0d with underflow; %0d mismatches.",
                 dates.checked_count, dates.underflow_count, dates.mismatch_count);
        if (dates.mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
